FILE: rtl/rfdr_pkg.sv
// Shared types, constants and helpers of the receive frame descriptor ring.
package rfdr_pkg;

  // Buffer and ring geometry.
  localparam int BUFFER_BYTES = 2048;
  localparam int SLOT_COUNT   = 16;

  // Field widths.
  localparam int FILL_W  = $clog2(BUFFER_BYTES + 1);
  localparam int OFF_W   = $clog2(BUFFER_BYTES);
  localparam int LEN_W   = FILL_W;
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int CHUNK_W = 8;
  localparam int MAXF_W  = 12;
  localparam int CMP_W   = (FILL_W > MAXF_W) ? FILL_W : MAXF_W;

  // Reset value of the frame size threshold register.
  localparam logic [MAXF_W-1:0] MAX_FRAME_RESET = MAXF_W'(256);

  // Buffer limits at the fill count width.
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BUFFER_BYTES - 1);

  // Item operation codes.
  localparam logic OP_CHUNK = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_POLL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic chunk_en;  // Apply a received chunk and present its result.
    logic poll_rd;   // Read the descriptor at the read slot.
    logic poll_out;  // Present the poll result and advance the read slot on a hit.
  } ctrl_cmd_t;

  // Ring successor: slots wrap before the last one.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W:0] n;
    n = {1'b0, s} + (SLOT_W+1)'(1);
    if (n >= (SLOT_W+1)'(SLOT_COUNT - 1)) begin
      n = '0;
    end
    return n[SLOT_W-1:0];
  endfunction

endpackage

FILE: rtl/rx_frame_descriptor_ring_top.sv
// Top level of the receive frame descriptor ring.
// A chunk item is taken in any cycle that busy_o is low and its result shows on the
// result ports with done_o in the next cycle, so chunks may follow back to back. A poll
// item goes through the registered read of the descriptor memory: busy_o is high
// in the cycle after the poll is taken and the result shows with done_o in the cycle
// after that. Every result is valid for exactly one cycle and must be taken then; the
// receiver cannot stall. The user must write the frame size threshold with cfg_we_i
// only while no item is in flight; the block itself does not enforce this.
module rx_frame_descriptor_ring_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         op_i,
  input  logic [rfdr_pkg::CHUNK_W-1:0] chunk_bytes_i,
  input  logic                         frame_end_i,
  input  logic                         cfg_we_i,
  input  logic [rfdr_pkg::MAXF_W-1:0]  cfg_wdata_i,
  output logic                         done_o,
  output logic [rfdr_pkg::OFF_W-1:0]   write_offset_o,
  output logic                         frame_valid_o,
  output logic [rfdr_pkg::OFF_W-1:0]   frame_start_o,
  output logic [rfdr_pkg::LEN_W-1:0]   frame_length_o
);

  rfdr_pkg::ctrl_cmd_t cmd;

  // Sequencing of items.
  rfdr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Buffer bookkeeping and descriptor storage.
  rfdr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .chunk_bytes_i  (chunk_bytes_i),
    .frame_end_i    (frame_end_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .write_offset_o (write_offset_o),
    .frame_valid_o  (frame_valid_o),
    .frame_start_o  (frame_start_o),
    .frame_length_o (frame_length_o)
  );

endmodule

FILE: rtl/rfdr_ctrl.sv
// Controller state machine that sequences chunk and poll items.
module rfdr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               op_i,
  output logic               busy_o,
  output rfdr_pkg::ctrl_cmd_t cmd_o
);

  rfdr_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfdr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      rfdr_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op_i == rfdr_pkg::OP_POLL) begin
            cmd_o.poll_rd = 1'b1;
            state_d       = rfdr_pkg::ST_POLL;
          end else begin
            cmd_o.chunk_en = 1'b1;
          end
        end
      end
      rfdr_pkg::ST_POLL: begin
        busy_o         = 1'b1;
        cmd_o.poll_out = 1'b1;
        state_d        = rfdr_pkg::ST_IDLE;
      end
      default: begin
        state_d = rfdr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rfdr_datapath.sv
// Datapath: fill count, ring pointers, descriptor memory and result registers.
module rfdr_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rfdr_pkg::ctrl_cmd_t               cmd_i,
  input  logic [rfdr_pkg::CHUNK_W-1:0]      chunk_bytes_i,
  input  logic                              frame_end_i,
  input  logic                              cfg_we_i,
  input  logic [rfdr_pkg::MAXF_W-1:0]       cfg_wdata_i,
  output logic                              done_o,
  output logic [rfdr_pkg::OFF_W-1:0]        write_offset_o,
  output logic                              frame_valid_o,
  output logic [rfdr_pkg::OFF_W-1:0]        frame_start_o,
  output logic [rfdr_pkg::LEN_W-1:0]        frame_length_o
);

  localparam int ENTRY_W = rfdr_pkg::OFF_W + rfdr_pkg::LEN_W;

  // Control state.
  logic [rfdr_pkg::MAXF_W-1:0] max_frame_q;
  logic [rfdr_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [rfdr_pkg::SLOT_W-1:0] wslot_q, rslot_q;
  logic [rfdr_pkg::OFF_W-1:0]  open_start_q, open_start_d;
  logic                        hit_q;
  logic                        done_q;

  // Descriptor memory and its registered read data.
  logic [ENTRY_W-1:0] desc_mem [rfdr_pkg::SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_data_q;

  // Result registers.
  logic [rfdr_pkg::OFF_W-1:0] woff_q;
  logic                       fvalid_q;
  logic [rfdr_pkg::OFF_W-1:0] fstart_q;
  logic [rfdr_pkg::LEN_W-1:0] flen_q;

  // Chunk arithmetic.
  logic [rfdr_pkg::FILL_W:0]   sum;
  logic [rfdr_pkg::FILL_W-1:0] sat;
  logic [rfdr_pkg::FILL_W-1:0] open_ext;
  logic [rfdr_pkg::LEN_W-1:0]  close_len;
  logic [rfdr_pkg::FILL_W-1:0] room;
  logic                        keep_fill;
  logic [rfdr_pkg::OFF_W-1:0]  offset;

  // Saturating fill advance, closing length and the next frame start.
  always_comb begin
    sum      = {1'b0, fill_q} + (rfdr_pkg::FILL_W+1)'(chunk_bytes_i);
    sat      = (sum > {1'b0, rfdr_pkg::FILL_FULL}) ? rfdr_pkg::FILL_FULL
                                                   : sum[rfdr_pkg::FILL_W-1:0];
    open_ext = rfdr_pkg::FILL_W'(open_start_q);
    close_len = (sat >= open_ext) ? rfdr_pkg::LEN_W'(sat - open_ext) : '0;
    room      = rfdr_pkg::FILL_FULL - sat;
    keep_fill = (sat < rfdr_pkg::FILL_FULL) &&
                (rfdr_pkg::CMP_W'(room) >= rfdr_pkg::CMP_W'(max_frame_q));
    offset    = (fill_q > rfdr_pkg::FILL_LAST) ? rfdr_pkg::FILL_LAST[rfdr_pkg::OFF_W-1:0]
                                               : fill_q[rfdr_pkg::OFF_W-1:0];
    fill_d       = sat;
    open_start_d = open_start_q;
    if (frame_end_i) begin
      if (keep_fill) begin
        open_start_d = sat[rfdr_pkg::OFF_W-1:0];
      end else begin
        open_start_d = '0;
        fill_d       = '0;
      end
    end
  end

  // Threshold register, fill count, ring pointers and the open frame start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q  <= rfdr_pkg::MAX_FRAME_RESET;
      fill_q       <= '0;
      wslot_q      <= '0;
      rslot_q      <= '0;
      open_start_q <= '0;
      hit_q        <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.chunk_en | cmd_i.poll_out;
      if (cfg_we_i) begin
        max_frame_q <= cfg_wdata_i;
      end
      if (cmd_i.chunk_en) begin
        fill_q       <= fill_d;
        open_start_q <= open_start_d;
        if (frame_end_i) begin
          wslot_q <= rfdr_pkg::next_slot(wslot_q);
        end
      end
      if (cmd_i.poll_rd) begin
        hit_q <= (rslot_q != wslot_q);
      end
      if (cmd_i.poll_out && hit_q) begin
        rslot_q <= rfdr_pkg::next_slot(rslot_q);
      end
    end
  end

  // Descriptor memory: written when a frame closes, read on a poll.
  always_ff @(posedge clk_i) begin
    if (cmd_i.chunk_en && frame_end_i) begin
      desc_mem[wslot_q] <= {open_start_q, close_len};
    end
    if (cmd_i.poll_rd) begin
      rd_data_q <= desc_mem[rslot_q];
    end
  end

  // Result registers for both item kinds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.chunk_en) begin
      woff_q   <= offset;
      fvalid_q <= 1'b0;
      fstart_q <= '0;
      flen_q   <= '0;
    end else if (cmd_i.poll_out) begin
      woff_q   <= '0;
      fvalid_q <= hit_q;
      fstart_q <= hit_q ? rd_data_q[ENTRY_W-1 -: rfdr_pkg::OFF_W] : '0;
      flen_q   <= hit_q ? rd_data_q[rfdr_pkg::LEN_W-1:0] : '0;
    end
  end

  assign done_o         = done_q;
  assign write_offset_o = woff_q;
  assign frame_valid_o  = fvalid_q;
  assign frame_start_o  = fstart_q;
  assign frame_length_o = flen_q;

endmodule

FILE: rtl/rfdr_checker.sv
// Port-level checker of the receive frame descriptor ring and its bind statement.
module rfdr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         op_i,
  input logic                         done_o,
  input logic [rfdr_pkg::OFF_W-1:0]   write_offset_o,
  input logic                         frame_valid_o,
  input logic [rfdr_pkg::OFF_W-1:0]   frame_start_o,
  input logic [rfdr_pkg::LEN_W-1:0]   frame_length_o
);

  // A chunk item yields a non-frame result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == rfdr_pkg::OP_CHUNK) |=> (done_o && !frame_valid_o))
    else $error("chunk item did not give its result in the next cycle");

  // A poll item holds the block busy in the next cycle, then gives its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == rfdr_pkg::OP_POLL) |=> (busy_o && !done_o) ##1
    (done_o && !busy_o))
    else $error("poll item did not finish in two cycles");

  // A result with a frame carries no write offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && frame_valid_o) |-> (write_offset_o == '0))
    else $error("frame result with nonzero write offset");

  // A result without a frame carries an empty descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !frame_valid_o) |-> (frame_start_o == '0 && frame_length_o == '0))
    else $error("empty result with nonzero descriptor");

endmodule

bind rx_frame_descriptor_ring_top rfdr_checker u_rfdr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .op_i           (op_i),
  .done_o         (done_o),
  .write_offset_o (write_offset_o),
  .frame_valid_o  (frame_valid_o),
  .frame_start_o  (frame_start_o),
  .frame_length_o (frame_length_o)
);
